// ----- hdl/glsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph shelf packer package
// Shared types and constants for the glyph atlas allocator.
// ----------------------------------------------------------------------------
package glsp_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int CFG_W           = 13;
  localparam int CNT_CFG_W       = 9;
  localparam int PAD_W           = 4;
  localparam int ROW_W           = 14;
  localparam logic [ROW_W-1:0] ROW_MAX = 14'd16383;

  localparam logic [12:0] ATLAS_W_RST = 13'd1024;
  localparam logic [12:0] ATLAS_H_RST = 13'd1024;
  localparam logic [8:0]  MAX_ENT_RST = 9'd256;
  localparam logic [3:0]  PAD_RST     = 4'd1;

  localparam logic [1:0] REG_ATLAS_W = 2'd0;
  localparam logic [1:0] REG_ATLAS_H = 2'd1;
  localparam logic [1:0] REG_MAX_ENT = 2'd2;
  localparam logic [1:0] REG_PADDING = 2'd3;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_NEW    = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef struct packed {
    logic [20:0] cp;
    logic [11:0] ph;
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } entry_t;

  typedef struct packed {
    logic wrap_step;
    logic place_step;
  } cur_cmd_t;

  typedef struct packed {
    logic [12:0] aw;
    logic [12:0] ah;
    logic [3:0]  pad;
  } geom_t;

endpackage

// ----- hdl/glyph_shelf_packer_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph shelf packer cache
// Keyed shelf-packing rectangle allocator for a glyph texture atlas.
// ----------------------------------------------------------------------------
// Sequence: a hit on the first probe passes through S_PROBE and S_OUT into the
// output register; a find miss or an early rejection adds S_CHECK, and an add that
// reaches placement adds S_CHECK and S_PLACE; each extra probe repeats S_PROBE.
// One request at a time: s_tready is high only in S_IDLE, which is re-entered as
// the result is registered, and later while a result is stalled.
// Reset (rst, synchronous) empties the table, clears the cursor and loads defaults.
// ----------------------------------------------------------------------------
module glyph_shelf_packer_cache #(
  parameter int TABLE_DEPTH = glsp_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata from bit 0: codepoint[20:0], font_px[11:0], bmp_w[12:0],
  // bmp_h[12:0], load_ok, bitmap_ok, three zero bits.
  input  logic [63:0] s_tdata,
  // tuser: op (0 add, 1 find).
  input  logic        s_tuser,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata from bit 0: place_x[11:0], place_y[11:0], place_w[12:0],
  // place_h[12:0], six zero bits.
  output logic [55:0] m_tdata,
  // tuser: status (0 found, 1 newly placed, 2 rejected or not found).
  output logic [1:0]  m_tuser,
  // Register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_addr,
  input  logic [12:0] cfg_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > glsp_pkg::CNT_CFG_W) ? CW : glsp_pkg::CNT_CFG_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // Fold the 33-bit key onto the table index, then bring it below the depth.
  function automatic logic [IW-1:0] key_hash(input logic [32:0] key);
    logic [IW:0] h;
    h = '0;
    for (int i = 0; i < 33; i++) begin
      h[i % IW] = h[i % IW] ^ key[i];
    end
    if (h >= (IW + 1)'(TABLE_DEPTH)) begin
      h = h - (IW + 1)'(TABLE_DEPTH);
    end
    return h[IW-1:0];
  endfunction

  // Configuration registers.
  glsp_pkg::geom_t geom;
  logic [8:0]      max_ent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.aw <= glsp_pkg::ATLAS_W_RST;
      geom.ah <= glsp_pkg::ATLAS_H_RST;
      geom.pad <= glsp_pkg::PAD_RST;
      max_ent <= glsp_pkg::MAX_ENT_RST;
    end else if (cfg_valid && (cfg_addr[7:2] == 6'd0)) begin
      case (cfg_addr[1:0])
        glsp_pkg::REG_ATLAS_W: geom.aw  <= cfg_data;
        glsp_pkg::REG_ATLAS_H: geom.ah  <= cfg_data;
        glsp_pkg::REG_MAX_ENT: max_ent  <= cfg_data[8:0];
        glsp_pkg::REG_PADDING: geom.pad <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Request holding registers.
  logic [2:0]  state;
  logic        req_op;
  logic [20:0] req_cp;
  logic [11:0] req_ph;
  logic [12:0] req_gw;
  logic [12:0] req_gh;
  logic        req_ld;
  logic        req_bm;
  logic [IW-1:0] probe_idx;
  logic [IW-1:0] probe_cnt;
  logic [1:0]  res_status;
  logic [11:0] res_x;
  logic [11:0] res_y;
  logic [12:0] res_w;
  logic [12:0] res_h;

  logic             s_acc;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    next_idx;
  glsp_pkg::entry_t rd_data;
  logic             rd_vld;
  logic             hit;
  logic             wr_en;
  glsp_pkg::entry_t wr_data;
  glsp_pkg::cur_cmd_t cmd;
  logic [12:0]      cur_col;
  logic [13:0]      cur_row;
  logic [CW-1:0]    count;
  logic             fits;
  logic             reject_pre;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign next_idx = (probe_idx == IW'(TABLE_DEPTH - 1)) ? '0 : probe_idx + IW'(1);
  assign hit      = rd_vld && (rd_data.cp == req_cp) && (rd_data.ph == req_ph);

  // A read is issued on acceptance at the hashed slot, and again for each
  // further probe while occupied slots hold other keys.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = next_idx;
    if (s_acc) begin
      rd_en   = 1'b1;
      rd_addr = key_hash({s_tdata[20:0], s_tdata[32:21]});
    end else if (state == S_PROBE && !hit && rd_vld &&
                 probe_cnt != IW'(TABLE_DEPTH - 1)) begin
      rd_en = 1'b1;
    end
  end

  // Checks that do not depend on the cursor.
  assign reject_pre = (req_op == glsp_pkg::OP_FIND) ||
                      (XW'(count) >= XW'(max_ent)) ||
                      (count >= CW'(TABLE_DEPTH)) ||
                      (req_ph == 12'd0) || !req_ld ||
                      (req_gw == 13'd0) || (req_gh == 13'd0) ||
                      ({1'b0, req_gw} + {10'b0, geom.pad} > {1'b0, geom.aw}) ||
                      ({1'b0, req_gh} + {10'b0, geom.pad} > {1'b0, geom.ah});

  assign cmd.wrap_step  = (state == S_CHECK) && !reject_pre;
  assign cmd.place_step = (state == S_PLACE) && fits && req_bm;
  assign wr_en          = cmd.place_step;
  assign wr_data        = '{cp: req_cp, ph: req_ph, x: cur_col[11:0], y: cur_row[11:0],
                            w: req_gw, h: req_gh};

  glsp_table #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rd_vld  (rd_vld),
    .wr_en   (wr_en),
    .wr_addr (probe_idx),
    .wr_data (wr_data)
  );

  glsp_cursor #(
    .CW (CW)
  ) u_cursor (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .geom  (geom),
    .gw    (req_gw),
    .gh    (req_gh),
    .col   (cur_col),
    .row   (cur_row),
    .count (count),
    .fits  (fits)
  );

  // Sequencer: probe the table, then check and place on a miss.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (hit) begin
            state <= S_OUT;
          end else if (!rd_vld || probe_cnt == IW'(TABLE_DEPTH - 1)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: state <= reject_pre ? S_OUT : S_PLACE;
        S_PLACE: state <= S_OUT;
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      req_op    <= s_tuser;
      req_cp    <= s_tdata[20:0];
      req_ph    <= s_tdata[32:21];
      req_gw    <= s_tdata[45:33];
      req_gh    <= s_tdata[58:46];
      req_ld    <= s_tdata[59];
      req_bm    <= s_tdata[60];
      probe_idx <= rd_addr;
      probe_cnt <= '0;
    end else if (rd_en) begin
      probe_idx <= next_idx;
      probe_cnt <= probe_cnt + IW'(1);
    end
    if (state == S_PROBE && hit) begin
      res_status <= glsp_pkg::ST_FOUND;
      res_x <= rd_data.x;
      res_y <= rd_data.y;
      res_w <= rd_data.w;
      res_h <= rd_data.h;
    end else if ((state == S_CHECK && reject_pre) ||
                 (state == S_PLACE && !cmd.place_step)) begin
      res_status <= glsp_pkg::ST_REJECT;
      res_x <= '0;
      res_y <= '0;
      res_w <= '0;
      res_h <= '0;
    end else if (cmd.place_step) begin
      res_status <= glsp_pkg::ST_NEW;
      res_x <= cur_col[11:0];
      res_y <= cur_row[11:0];
      res_w <= req_gw;
      res_h <= req_gh;
    end
  end

  // Output register: holds a result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tuser <= res_status;
      m_tdata <= {6'b0, res_h, res_w, res_y, res_x};
    end
  end

endmodule

// ----- hdl/glsp_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph entry table
// Single-port-read, single-port-write entry memory with per-entry valid bits.
// ----------------------------------------------------------------------------
module glsp_table #(
  parameter int DEPTH = glsp_pkg::TABLE_DEPTH_DEF,
  parameter int IW    = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IW-1:0]    rd_addr,
  output glsp_pkg::entry_t rd_data,
  output logic             rd_vld,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_addr,
  input  glsp_pkg::entry_t wr_data
);

  glsp_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld_bits;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Valid bits are flops so that reset empties the table at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_bits <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_bits[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld_bits[rd_addr];
      end
    end
  end

endmodule

// ----- hdl/glsp_cursor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph shelf cursor
// Holds the shelf cursor and entry count and performs wrap and advance.
// ----------------------------------------------------------------------------
module glsp_cursor #(
  parameter int CW = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  glsp_pkg::cur_cmd_t cmd,
  input  glsp_pkg::geom_t    geom,
  input  logic [12:0]        gw,
  input  logic [12:0]        gh,
  output logic [12:0]        col,
  output logic [13:0]        row,
  output logic [CW-1:0]      count,
  output logic               fits
);

  logic [12:0] shelf;
  logic [14:0] col_end;
  logic        wrap;
  logic [15:0] row_wrap;
  logic [15:0] row_end;

  assign col_end  = {2'b0, col} + {2'b0, gw} + {11'b0, geom.pad};
  assign wrap     = col_end > {2'b0, geom.aw};
  assign row_wrap = {2'b0, row} + {3'b0, shelf} + {12'b0, geom.pad};
  assign row_end  = {2'b0, row} + {3'b0, gh} + {12'b0, geom.pad};
  assign fits     = row_end <= {3'b0, geom.ah};

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      shelf <= '0;
      count <= '0;
    end else if (cmd.wrap_step && wrap) begin
      col   <= '0;
      shelf <= '0;
      row   <= (row_wrap > {2'b0, glsp_pkg::ROW_MAX}) ? glsp_pkg::ROW_MAX : row_wrap[13:0];
    end else if (cmd.place_step) begin
      col   <= col_end[12:0];
      count <= count + CW'(1);
      if (gh > shelf) begin
        shelf <= gh;
      end
    end
  end

endmodule

// ----- hdl/glsp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph shelf packer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module glsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("undefined status");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == glsp_pkg::ST_REJECT |-> m_tdata == 56'd0)
    else $error("rejected result carries a placement");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in flight");

endmodule

bind glyph_shelf_packer_cache glsp_checker u_glsp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
